// File: rtl/core/mcawa_pkg.sv
package mcawa_pkg;

    localparam int CHANNELS   = 4;
    localparam int WINDOW     = 10;
    localparam int OUT_FIELDS = 4;

    localparam int DATA_W   = 24;
    localparam int CODE_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int DEPTH    = CHANNELS * WINDOW;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W    = $clog2(WINDOW);
    localparam int CH_W     = $clog2(OUT_FIELDS);
    localparam int SUM_W    = DATA_W + $clog2(WINDOW);

    // reciprocal of the window length, scaled by 2^32
    localparam int          RECIP_SHIFT = 32;
    localparam logic [31:0] RECIP       = 32'((64'h1_0000_0000) / WINDOW);

    localparam logic [DATA_W-1:0] FULL_SCALE = 24'h7F_FFFF;

    localparam logic [1:0] ACT_CONV = 2'd0;
    localparam logic [1:0] ACT_SCAN = 2'd1;
    localparam logic [1:0] ACT_AVG  = 2'd2;

    typedef struct packed {
        logic                     start;
        logic signed [SUM_W-1:0]  sum;
    } t_div_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] mean;
    } t_div_rsp;

endpackage

// File: rtl/core/mcawa_mean_div.sv
module mcawa_mean_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcawa_pkg::t_div_req i_req,
    output mcawa_pkg::t_div_rsp o_rsp
);
    import mcawa_pkg::*;

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_ABS  = 5'b00010,
        D_MUL  = 5'b00100,
        D_REM  = 5'b01000,
        D_FIX  = 5'b10000
    } t_dstate;

    t_dstate                  r_state, n_state;
    logic signed [SUM_W-1:0]  r_sum;
    logic                     r_neg;
    logic [SUM_W-1:0]         r_mag;
    logic [SUM_W-1:0]         r_quo;
    logic [SUM_W-1:0]         r_rem;
    logic                     r_done;
    logic signed [DATA_W-1:0] r_mean;

    logic [SUM_W+31:0]        n_prod;
    logic [SUM_W-1:0]         n_q;

    assign n_prod = (SUM_W+32)'(r_mag) * (SUM_W+32)'(RECIP);
    // estimate may sit one below the true quotient
    assign n_q    = r_quo + ((r_rem >= SUM_W'(WINDOW)) ? SUM_W'(1) : SUM_W'(0));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE:  if (i_req.start) n_state = D_ABS;
            D_ABS:   n_state = D_MUL;
            D_MUL:   n_state = D_REM;
            D_REM:   n_state = D_FIX;
            D_FIX:   n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == D_FIX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_req.start) begin
            r_sum <= i_req.sum;
        end
        if (r_state == D_ABS) begin
            r_neg <= r_sum[SUM_W-1];
            r_mag <= r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        end
        if (r_state == D_MUL) begin
            r_quo <= n_prod[SUM_W+31:RECIP_SHIFT];
        end
        if (r_state == D_REM) begin
            r_rem <= r_mag - SUM_W'(r_quo * WINDOW);
        end
        if (r_state == D_FIX) begin
            r_mean <= r_neg ? DATA_W'(-n_q) : DATA_W'(n_q);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.mean = r_mean;

endmodule

// File: rtl/core/multichannel_adc_window_averager.sv
// multichannel converter window averager
//
// input channel (i_in_valid / o_in_ready) carries one event word: a
// conversion result, a scan-end tick or an average request. results go into
// a CHANNELS x WINDOW sample memory at the shared write slot; a scan end
// advances the slot. an average request walks every channel's window through
// one accumulator and a reciprocal divider and returns one word with the
// four truncated means on the output channel (o_out_valid / i_out_ready).
//
// conversion results and scan ends make no word.
// an average request keeps o_in_ready low until its word is loaded into the
// output register: WINDOW memory reads per channel through the single
// read port, one tail add, then the shared divider.
// the result sits in an output register, so the block takes new events while
// a word waits; a further average request waits only for that register.
// reset clears the write slot and the per-entry valid flags, so every stored
// sample reads as zero until written; no clearing pass is needed.
module multichannel_adc_window_averager (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_action,
    input  logic [mcawa_pkg::CODE_W-1:0]       i_channel_code,
    input  logic                               i_error_flag,
    input  logic                               i_overflow_flag,
    input  logic [mcawa_pkg::DATA_W-1:0]       i_raw_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [mcawa_pkg::DATA_W-1:0] o_mean_chan0,
    output logic signed [mcawa_pkg::DATA_W-1:0] o_mean_chan1,
    output logic signed [mcawa_pkg::DATA_W-1:0] o_mean_chan2,
    output logic signed [mcawa_pkg::DATA_W-1:0] o_mean_chan3
);
    import mcawa_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SUM  = 5'b00010,
        S_TAIL = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                   r_state;
    logic [SLOT_W-1:0]        r_slot;
    logic [CH_W-1:0]          r_ch;
    logic [IDX_W-1:0]         r_idx;
    logic                     r_pend;
    logic signed [SUM_W-1:0]  r_acc, n_acc;

    logic [DATA_W-1:0]        r_mem [DEPTH];
    logic [DEPTH-1:0]         r_valid;
    logic [DATA_W-1:0]        r_rd_data;
    logic                     r_rd_valid;

    logic signed [DATA_W-1:0] r_mean [OUT_FIELDS];
    logic signed [DATA_W-1:0] r_out  [OUT_FIELDS];
    logic                     r_out_valid;

    logic                     in_acc;
    logic                     wr_en;
    logic [ADDR_W-1:0]        wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [SUM_W-1:0]  contrib;
    logic                     load_out;
    t_div_req                 div_req;
    t_div_rsp                 div_rsp;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // store only for a real channel and a slot inside the window
    assign wr_en   = in_acc && (i_action == ACT_CONV) && (i_channel_code != '0)
                     && (32'(i_channel_code) <= CHANNELS) && (32'(r_slot) < WINDOW);
    assign wr_addr = ADDR_W'((32'(i_channel_code) - 1) * WINDOW + 32'(r_slot));
    assign wr_data = (i_error_flag || i_overflow_flag) ? FULL_SCALE : i_raw_count;

    assign rd_addr = ADDR_W'(32'(r_ch) * WINDOW + 32'(r_idx));
    assign contrib = r_rd_valid ? SUM_W'($signed(r_rd_data)) : '0;
    assign n_acc   = r_acc + contrib;

    assign div_req.start = (r_state == S_TAIL);
    assign div_req.sum   = n_acc;

    assign load_out = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    mcawa_mean_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (r_state == S_SUM) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (r_state == S_SUM) begin
                r_rd_valid <= r_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_ch        <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_action == ACT_SCAN) begin
                        if (32'(r_slot) >= WINDOW - 1) begin
                            r_slot <= '0;
                        end else begin
                            r_slot <= r_slot + 1'b1;
                        end
                    end
                    if (in_acc && i_action == ACT_AVG) begin
                        r_ch    <= '0;
                        r_idx   <= '0;
                        r_pend  <= 1'b0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_pend <= 1'b1;
                    if (32'(r_idx) == WINDOW - 1) begin
                        r_state <= S_TAIL;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_TAIL: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        if (32'(r_ch) == CHANNELS - 1) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch    <= r_ch + 1'b1;
                            r_idx   <= '0;
                            r_pend  <= 1'b0;
                            r_state <= S_SUM;
                        end
                    end
                end
                S_OUT: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // accumulator and per-channel means
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_acc <= '0;
        end else if ((r_state == S_SUM && r_pend) || r_state == S_TAIL) begin
            r_acc <= n_acc;
        end else if (r_state == S_DIV && div_rsp.done) begin
            r_acc        <= '0;
            r_mean[r_ch] <= div_rsp.mean;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            for (int c = 0; c < OUT_FIELDS; c++) begin
                r_out[c] <= (c < CHANNELS) ? r_mean[c] : '0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_mean_chan0 = r_out[0];
    assign o_mean_chan1 = r_out[1];
    assign o_mean_chan2 = r_out[2];
    assign o_mean_chan3 = r_out[3];

    a_avg_starts_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_action == ACT_AVG) |=> (r_state == S_SUM))
        else $error("average request did not start the window walk");

    a_slot_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_slot) < WINDOW)
        else $error("write slot left the window");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide phase");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_OUT))
        else $error("output word raised without a finished walk");

    a_ch_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_ch) < CHANNELS)
        else $error("channel counter out of range");

endmodule
